// ===== sv/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token codes and the fixed word list of the source tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int PosWidth = 16;
   localparam int RspDepth = 4;
   localparam int RspAw    = $clog2(RspDepth);

   typedef logic [PosWidth-1:0] pos_type;

   typedef enum logic [7:0] {
      ModeIdle  = 8'b0000_0001,
      ModeNum   = 8'b0000_0010,
      ModeIdent = 8'b0000_0100,
      ModeStr   = 8'b0000_1000,
      ModeSlash = 8'b0001_0000,
      ModeLcom  = 8'b0010_0000,
      ModeBcom  = 8'b0100_0000,
      ModeBstar = 8'b1000_0000
   } mode_type;

   localparam logic [3:0] TokEof     = 4'd0;
   localparam logic [3:0] TokNumber  = 4'd1;
   localparam logic [3:0] TokString  = 4'd2;
   localparam logic [3:0] TokBoolean = 4'd3;
   localparam logic [3:0] TokUndef   = 4'd4;
   localparam logic [3:0] TokNull    = 4'd5;
   localparam logic [3:0] TokIdent   = 4'd6;
   localparam logic [3:0] TokOper    = 4'd7;
   localparam logic [3:0] TokPunct   = 4'd8;
   localparam logic [3:0] TokKeyword = 4'd9;

   localparam logic [2:0] WordTrue  = 3'd4;
   localparam logic [2:0] WordFalse = 3'd5;
   localparam logic [2:0] WordUndef = 3'd6;

   localparam logic [7:0] ChEos   = 8'h00;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChStar  = 8'h2A;
   localparam logic [7:0] ChDot   = 8'h2E;
   localparam logic [7:0] ChSlash = 8'h2F;

   // word text, left aligned in nine characters
   localparam logic [71:0] WordText [8] = '{
      "var      ", "print    ", "function ", "return   ",
      "true     ", "false    ", "undefined", "null     "
   };
   localparam logic [3:0] WordLen [8] = '{
      4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd5, 4'd9, 4'd4
   };

   typedef struct packed {
      logic [3:0]  token_type;
      logic [1:0]  word_code;
      logic [7:0]  first_char;
      logic [15:0] start_offset;
      logic [15:0] token_length;
      logic [15:0] line_number;
      logic [15:0] column_number;
      logic        last;
   } tok_type;

   typedef struct packed {
      logic [1:0] cnt;
      tok_type    tok0;
      tok_type    tok1;
   } push_type;

   function automatic pos_type sat_inc(input pos_type v);
      sat_inc = (v == '1) ? v : pos_type'(v + 1'b1);
   endfunction

   function automatic logic [7:0] word_char(input logic [2:0] w, input logic [3:0] k);
      logic [71:0] t;
      t = WordText[w];
      word_char = 8'h00;
      if (k < 4'd9) begin
         word_char = t[(8 - int'(k)) * 8 +: 8];
      end
   endfunction

   function automatic logic dec_digit(input logic [7:0] c);
      dec_digit = (c >= "0") && (c <= "9");
   endfunction

   function automatic logic name_char(input logic [7:0] c);
      name_char = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
                  (c == "_") || (c == "$");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      is_punct = (c == "=") || (c == ";") || (c == "(") || (c == ")") ||
                 (c == "{") || (c == "}") || (c == ChDot) || (c == ":") ||
                 (c == ",");
   endfunction

endpackage

// ===== sv/stt_if.sv =====
// ----------------------------------------------------------------------------
// stt_req_if / stt_rsp_if
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_type;
   logic [1:0]  word_code;
   logic [7:0]  first_char;
   logic [15:0] start_offset;
   logic [15:0] token_length;
   logic [15:0] line_number;
   logic [15:0] column_number;
   logic        last;

   modport source (output valid, output token_type, output word_code,
                   output first_char, output start_offset, output token_length,
                   output line_number, output column_number, output last,
                   input ready);
   modport sink (input valid, input token_type, input word_code,
                 input first_char, input start_offset, input token_length,
                 input line_number, input column_number, input last,
                 output ready);
endinterface

// ===== sv/stt_lex.sv =====
// ----------------------------------------------------------------------------
// stt_lex
// Scanner state and token forming: one byte per transfer, zero to two tokens.
// ----------------------------------------------------------------------------
module stt_lex (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         ch,
   output stt_pkg::push_type  push
);

   stt_pkg::mode_type mode_ff, mode_in;
   stt_pkg::pos_type  line_ff, line_in, col_ff, col_in, off_ff, off_in;
   stt_pkg::pos_type  ts_off_ff, ts_off_in, ts_line_ff, ts_line_in;
   stt_pkg::pos_type  ts_col_ff, ts_col_in, len_ff, len_in;
   logic [7:0]        first_ff, first_in;
   logic [7:0]        match_ff, match_in;

   stt_pkg::pos_type  adv_off, adv_line, adv_col;
   logic [7:0]        match_next, match_start;
   logic [3:0]        id_type;
   logic [1:0]        id_code;
   logic              dispatch, do_adv, pre_vld, dsp_vld;
   stt_pkg::tok_type  pre_tok, dsp_tok;

   function automatic logic [7:0] match_step(input logic [7:0] m,
                                             input stt_pkg::pos_type len,
                                             input logic [7:0] c);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = m[i] && (len < stt_pkg::pos_type'(stt_pkg::WordLen[i])) &&
                (stt_pkg::word_char(3'(i), len[3:0]) == c);
      end
      match_step = r;
   endfunction

   function automatic stt_pkg::tok_type mk_tok(input logic [3:0] ty, input logic [1:0] code,
                                               input logic [7:0] fc,
                                               input stt_pkg::pos_type off,
                                               input stt_pkg::pos_type len,
                                               input stt_pkg::pos_type ln,
                                               input stt_pkg::pos_type cl);
      stt_pkg::tok_type t;
      t.token_type    = ty;
      t.word_code     = code;
      t.first_char    = fc;
      t.start_offset  = 16'(off);
      t.token_length  = 16'(len);
      t.line_number   = 16'(ln);
      t.column_number = 16'(cl);
      t.last          = 1'b0;
      mk_tok = t;
   endfunction

   assign adv_off     = stt_pkg::sat_inc(off_ff);
   assign adv_line    = (ch == stt_pkg::ChLf) ? stt_pkg::sat_inc(line_ff) : line_ff;
   assign adv_col     = (ch == stt_pkg::ChLf) ? stt_pkg::pos_type'(1)
                                              : stt_pkg::sat_inc(col_ff);
   assign match_next  = match_step(match_ff, len_ff, ch);
   assign match_start = match_step(8'hFF, '0, ch);

   // first matching word of exact length decides the identifier class
   always_comb begin
      id_type = stt_pkg::TokIdent;
      id_code = 2'd0;
      for (int i = 7; i >= 0; i--) begin
         if (match_ff[i] && (len_ff == stt_pkg::pos_type'(stt_pkg::WordLen[i]))) begin
            if (i < 4) begin
               id_type = stt_pkg::TokKeyword;
               id_code = 2'(i);
            end else if (3'(i) == stt_pkg::WordTrue) begin
               id_type = stt_pkg::TokBoolean;
               id_code = 2'd1;
            end else if (3'(i) == stt_pkg::WordFalse) begin
               id_type = stt_pkg::TokBoolean;
               id_code = 2'd0;
            end else if (3'(i) == stt_pkg::WordUndef) begin
               id_type = stt_pkg::TokUndef;
               id_code = 2'd0;
            end else begin
               id_type = stt_pkg::TokNull;
               id_code = 2'd0;
            end
         end
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      off_in     = off_ff;
      ts_off_in  = ts_off_ff;
      ts_line_in = ts_line_ff;
      ts_col_in  = ts_col_ff;
      len_in     = len_ff;
      first_in   = first_ff;
      match_in   = match_ff;
      dispatch   = 1'b0;
      do_adv     = 1'b0;
      pre_vld    = 1'b0;
      dsp_vld    = 1'b0;
      pre_tok    = mk_tok(stt_pkg::TokNumber, 2'd0, first_ff, ts_off_ff, len_ff,
                          ts_line_ff, ts_col_ff);
      dsp_tok    = mk_tok(stt_pkg::TokEof, 2'd0, 8'h00, off_ff, '0, line_ff, col_ff);

      case (mode_ff)
         stt_pkg::ModeNum: begin
            if (stt_pkg::dec_digit(ch) || ch == stt_pkg::ChDot) begin
               len_in = stt_pkg::sat_inc(len_ff);
               do_adv = 1'b1;
            end else begin
               pre_vld  = 1'b1;
               dispatch = 1'b1;
            end
         end
         stt_pkg::ModeIdent: begin
            if (stt_pkg::name_char(ch) || stt_pkg::dec_digit(ch)) begin
               match_in = match_next;
               len_in   = stt_pkg::sat_inc(len_ff);
               do_adv   = 1'b1;
            end else begin
               pre_vld  = 1'b1;
               pre_tok  = mk_tok(id_type, id_code, first_ff, ts_off_ff, len_ff,
                                 ts_line_ff, ts_col_ff);
               dispatch = 1'b1;
            end
         end
         stt_pkg::ModeSlash: begin
            if (ch == stt_pkg::ChSlash) begin
               mode_in = stt_pkg::ModeLcom;
               do_adv  = 1'b1;
            end else if (ch == stt_pkg::ChStar) begin
               mode_in = stt_pkg::ModeBcom;
               do_adv  = 1'b1;
            end else begin
               len_in   = stt_pkg::pos_type'(1);
               pre_vld  = 1'b1;
               pre_tok  = mk_tok(stt_pkg::TokOper, 2'd0, first_ff, ts_off_ff,
                                 stt_pkg::pos_type'(1), ts_line_ff, ts_col_ff);
               dispatch = 1'b1;
            end
         end
         stt_pkg::ModeStr: begin
            pre_tok = mk_tok(stt_pkg::TokString, 2'd0, first_ff, ts_off_ff, len_ff,
                             ts_line_ff, ts_col_ff);
            if (ch == stt_pkg::ChQuote) begin
               pre_vld = 1'b1;
               do_adv  = 1'b1;
               mode_in = stt_pkg::ModeIdle;
            end else if (ch == stt_pkg::ChEos) begin
               pre_vld  = 1'b1;
               dispatch = 1'b1;
            end else begin
               len_in = stt_pkg::sat_inc(len_ff);
               do_adv = 1'b1;
            end
         end
         stt_pkg::ModeLcom: begin
            if (ch == stt_pkg::ChLf || ch == stt_pkg::ChEos) begin
               dispatch = 1'b1;
            end else begin
               do_adv = 1'b1;
            end
         end
         stt_pkg::ModeBcom: begin
            if (ch == stt_pkg::ChEos) begin
               dispatch = 1'b1;
            end else begin
               if (ch == stt_pkg::ChStar) begin
                  mode_in = stt_pkg::ModeBstar;
               end
               do_adv = 1'b1;
            end
         end
         stt_pkg::ModeBstar: begin
            if (ch == stt_pkg::ChEos) begin
               dispatch = 1'b1;
            end else begin
               if (ch == stt_pkg::ChSlash) begin
                  mode_in = stt_pkg::ModeIdle;
               end else if (ch != stt_pkg::ChStar) begin
                  mode_in = stt_pkg::ModeBcom;
               end
               do_adv = 1'b1;
            end
         end
         default: begin
            dispatch = 1'b1;
         end
      endcase

      if (dispatch) begin
         mode_in = stt_pkg::ModeIdle;
         if (ch == stt_pkg::ChEos) begin
            dsp_vld = 1'b1;
         end else if (stt_pkg::is_space(ch)) begin
            do_adv = 1'b1;
         end else if (stt_pkg::dec_digit(ch) || ch == stt_pkg::ChQuote ||
                      ch == stt_pkg::ChSlash || stt_pkg::name_char(ch)) begin
            ts_off_in  = off_ff;
            ts_line_in = line_ff;
            ts_col_in  = col_ff;
            first_in   = ch;
            len_in     = '0;
            do_adv     = 1'b1;
            if (stt_pkg::dec_digit(ch)) begin
               len_in  = stt_pkg::pos_type'(1);
               mode_in = stt_pkg::ModeNum;
            end else if (ch == stt_pkg::ChQuote) begin
               ts_off_in = adv_off;
               mode_in   = stt_pkg::ModeStr;
            end else if (ch == stt_pkg::ChSlash) begin
               mode_in = stt_pkg::ModeSlash;
            end else begin
               match_in = match_start;
               len_in   = stt_pkg::pos_type'(1);
               mode_in  = stt_pkg::ModeIdent;
            end
         end else begin
            dsp_vld = 1'b1;
            dsp_tok = mk_tok(stt_pkg::is_punct(ch) ? stt_pkg::TokPunct : stt_pkg::TokOper,
                             2'd0, ch, off_ff, stt_pkg::pos_type'(1), line_ff, col_ff);
            do_adv  = 1'b1;
         end
      end

      if (do_adv) begin
         off_in  = adv_off;
         line_in = adv_line;
         col_in  = adv_col;
      end else if (dsp_vld && ch == stt_pkg::ChEos) begin
         off_in  = '0;
         line_in = stt_pkg::pos_type'(1);
         col_in  = stt_pkg::pos_type'(1);
      end
   end

   // pack emitted tokens in order, marking the final one
   always_comb begin
      push.cnt  = 2'd0;
      push.tok0 = pre_vld ? pre_tok : dsp_tok;
      push.tok1 = dsp_tok;
      if (accept) begin
         push.cnt = 2'({1'b0, pre_vld} + {1'b0, dsp_vld});
      end
      push.tok0.last = !(pre_vld && dsp_vld);
      push.tok1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= stt_pkg::ModeIdle;
         line_ff    <= stt_pkg::pos_type'(1);
         col_ff     <= stt_pkg::pos_type'(1);
         off_ff     <= '0;
         ts_off_ff  <= '0;
         ts_line_ff <= stt_pkg::pos_type'(1);
         ts_col_ff  <= stt_pkg::pos_type'(1);
         len_ff     <= '0;
         first_ff   <= 8'h00;
         match_ff   <= 8'hFF;
      end else if (accept) begin
         mode_ff    <= mode_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         off_ff     <= off_in;
         ts_off_ff  <= ts_off_in;
         ts_line_ff <= ts_line_in;
         ts_col_ff  <= ts_col_in;
         len_ff     <= len_in;
         first_ff   <= first_in;
         match_ff   <= match_in;
      end
   end

endmodule

// ===== sv/stt_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// stt_rsp_fifo
// Token queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module stt_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  stt_pkg::push_type push,
   input  logic              pop,
   output stt_pkg::tok_type  head,
   output logic              not_empty,
   output logic              room_two
);

   stt_pkg::tok_type          mem [stt_pkg::RspDepth];
   logic [stt_pkg::RspAw-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [stt_pkg::RspAw:0]   cnt_ff, cnt_in;
   logic                      do_pop;

   assign not_empty = (cnt_ff != '0);
   assign room_two  = (cnt_ff <= (stt_pkg::RspAw+1)'(stt_pkg::RspDepth - 2));
   assign head      = mem[rp_ff];
   assign do_pop    = pop && not_empty;

   assign wp_in  = wp_ff + stt_pkg::RspAw'(push.cnt);
   assign rp_in  = rp_ff + stt_pkg::RspAw'(do_pop);
   assign cnt_in = cnt_ff + (stt_pkg::RspAw+1)'(push.cnt) - (stt_pkg::RspAw+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         mem[wp_ff] <= push.tok0;
      end
      if (push.cnt == 2'd2) begin
         mem[wp_ff + stt_pkg::RspAw'(1)] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== sv/source_text_tokenizer_core.sv =====
// A token is queued when the byte that ends it transfers; rsp shows the oldest token.
// Throughput: one byte per cycle; a byte may yield two tokens, and a four-entry token
// queue takes a new byte whenever it has room for two, so bytes stall only while
// tokens back up on rsp.
// Reset: synchronous; scanner idle at line 1, column 1, offset 0, queue empty.
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// Streaming source lexer: bytes in, tokens with type, word code and position out.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_chan,
   stt_rsp_if.source rsp_chan
);

   stt_pkg::push_type push;
   stt_pkg::tok_type  head;
   logic              accept, not_empty, room_two;

   assign req_chan.ready = room_two;
   assign accept         = req_chan.valid && room_two;

   stt_lex u_lex (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ch     (req_chan.ch),
      .push   (push)
   );

   stt_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_chan.ready),
      .head      (head),
      .not_empty (not_empty),
      .room_two  (room_two)
   );

   assign rsp_chan.valid         = not_empty;
   assign rsp_chan.token_type    = head.token_type;
   assign rsp_chan.word_code     = head.word_code;
   assign rsp_chan.first_char    = head.first_char;
   assign rsp_chan.start_offset  = head.start_offset;
   assign rsp_chan.token_length  = head.token_length;
   assign rsp_chan.line_number   = head.line_number;
   assign rsp_chan.column_number = head.column_number;
   assign rsp_chan.last          = head.last;

endmodule

// ===== sv/stt_checker.sv =====
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the token channel of the tokenizer.
// ----------------------------------------------------------------------------
module stt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_token_type,
   input logic [15:0] rsp_token_length,
   input logic [15:0] rsp_line_number,
   input logic [15:0] rsp_column_number,
   input logic        rsp_last
);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token shown right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("token dropped before transfer");

   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_type == stt_pkg::TokEof |-> rsp_last && rsp_token_length == 16'd0)
      else $error("eof token not last or nonzero length");

   a_single_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_type == stt_pkg::TokOper || rsp_token_type == stt_pkg::TokPunct)
      |-> rsp_token_length == 16'd1)
      else $error("operator or punctuator length not one");

   a_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_number != 16'd0 && rsp_column_number != 16'd0)
      else $error("zero line or column");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_token_type    (rsp_chan.token_type),
   .rsp_token_length  (rsp_chan.token_length),
   .rsp_line_number   (rsp_chan.line_number),
   .rsp_column_number (rsp_chan.column_number),
   .rsp_last          (rsp_chan.last)
);

// ===== dv/source_text_tokenizer_checker.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_checker
// Watches the byte and token channels of the tokenizer, predicts the tokens
// each accepted byte yields and compares every token transfer, field by field,
// against the oldest prediction. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module source_text_tokenizer_checker
   import stt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   stt_req_if   req_mon,
   stt_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);

   localparam logic [1:0] CodeNone  = 2'd0;
   localparam logic [1:0] CodeFalse = 2'd0;
   localparam logic [1:0] CodeTrue  = 2'd1;
   localparam pos_type    PosTop    = '1;

   string      vocab [8] = '{"var", "print", "function", "return",
                             "true", "false", "undefined", "null"};
   tok_type    tokens_due [$];
   tok_type    fresh [2];
   int         fresh_n;
   mode_type   scan_mode;
   pos_type    at_line, at_col, at_off;
   pos_type    tok_off, tok_line, tok_col, tok_len;
   logic [7:0] tok_ch;
   logic [7:0] word_hits;

   function automatic pos_type bump(pos_type v);
      return (v == PosTop) ? v : pos_type'(v + 1'b1);
   endfunction

   function automatic bit digit_ch(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic bit alpha_ch(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             (c == "_") || (c == "$");
   endfunction

   function automatic bit space_ch(logic [7:0] c);
      return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
   endfunction

   function automatic bit punct_ch(logic [7:0] c);
      return (c == "=") || (c == ";") || (c == "(") || (c == ")") || (c == "{") ||
             (c == "}") || (c == ChDot) || (c == ":") || (c == ",");
   endfunction

   function automatic void step_pos(logic [7:0] c);
      at_off = bump(at_off);
      if (c == ChLf) begin
         at_line = bump(at_line);
         at_col  = 16'd1;
      end else begin
         at_col = bump(at_col);
      end
   endfunction

   function automatic void open_tok(logic [7:0] c);
      tok_off  = at_off;
      tok_line = at_line;
      tok_col  = at_col;
      tok_ch   = c;
      tok_len  = '0;
   endfunction

   function automatic void narrow_words(logic [7:0] c);
      for (int i = 0; i < 8; i++) begin
         if (word_hits[i] && !((int'(tok_len) < vocab[i].len()) &&
                               (vocab[i][int'(tok_len)] == c)))
            word_hits[i] = 1'b0;
      end
   endfunction

   function automatic tok_type make_tok(logic [3:0] kind, logic [1:0] code,
                                        logic [7:0] first, pos_type off, pos_type len,
                                        pos_type line, pos_type col);
      tok_type t;
      t.token_type    = kind;
      t.word_code     = code;
      t.first_char    = first;
      t.start_offset  = off;
      t.token_length  = len;
      t.line_number   = line;
      t.column_number = col;
      t.last          = 1'b0;
      return t;
   endfunction

   function automatic tok_type held_tok(logic [3:0] kind, logic [1:0] code);
      return make_tok(kind, code, tok_ch, tok_off, tok_len, tok_line, tok_col);
   endfunction

   // lowest matching word index wins
   function automatic tok_type word_tok();
      logic [3:0] kind;
      logic [1:0] code;
      logic [2:0] w;
      kind = TokIdent;
      code = CodeNone;
      for (int i = 7; i >= 0; i--) begin
         w = 3'(i);
         if (word_hits[i] && (int'(tok_len) == vocab[i].len())) begin
            if (w < WordTrue) begin
               kind = TokKeyword;
               code = w[1:0];
            end else if (w == WordTrue) begin
               kind = TokBoolean;
               code = CodeTrue;
            end else if (w == WordFalse) begin
               kind = TokBoolean;
               code = CodeFalse;
            end else if (w == WordUndef) begin
               kind = TokUndef;
               code = CodeNone;
            end else begin
               kind = TokNull;
               code = CodeNone;
            end
         end
      end
      return held_tok(kind, code);
   endfunction

   function automatic void keep(tok_type t);
      fresh[fresh_n] = t;
      fresh_n++;
   endfunction

   function automatic void lex_byte(logic [7:0] c);
      bit scan;
      fresh_n = 0;
      scan    = 1'b1;
      case (scan_mode)
         ModeNum: begin
            if (digit_ch(c) || (c == ChDot)) begin
               tok_len = bump(tok_len);
               step_pos(c);
               scan = 1'b0;
            end else begin
               keep(held_tok(TokNumber, CodeNone));
               scan_mode = ModeIdle;
            end
         end
         ModeIdent: begin
            if (alpha_ch(c) || digit_ch(c)) begin
               narrow_words(c);
               tok_len = bump(tok_len);
               step_pos(c);
               scan = 1'b0;
            end else begin
               keep(word_tok());
               scan_mode = ModeIdle;
            end
         end
         ModeSlash: begin
            if (c == ChSlash) begin
               scan_mode = ModeLcom;
               step_pos(c);
               scan = 1'b0;
            end else if (c == ChStar) begin
               scan_mode = ModeBcom;
               step_pos(c);
               scan = 1'b0;
            end else begin
               tok_len = 16'd1;
               keep(held_tok(TokOper, CodeNone));
               scan_mode = ModeIdle;
            end
         end
         ModeStr: begin
            if (c == ChQuote) begin
               keep(held_tok(TokString, CodeNone));
               step_pos(c);
               scan_mode = ModeIdle;
               scan = 1'b0;
            end else if (c == ChEos) begin
               keep(held_tok(TokString, CodeNone));
               scan_mode = ModeIdle;
            end else begin
               tok_len = bump(tok_len);
               step_pos(c);
               scan = 1'b0;
            end
         end
         ModeLcom: begin
            if ((c == ChLf) || (c == ChEos)) begin
               scan_mode = ModeIdle;
            end else begin
               step_pos(c);
               scan = 1'b0;
            end
         end
         ModeBcom: begin
            if (c == ChEos) begin
               scan_mode = ModeIdle;
            end else begin
               if (c == ChStar) scan_mode = ModeBstar;
               step_pos(c);
               scan = 1'b0;
            end
         end
         ModeBstar: begin
            if (c == ChEos) begin
               scan_mode = ModeIdle;
            end else begin
               if (c == ChSlash) scan_mode = ModeIdle;
               else if (c != ChStar) scan_mode = ModeBcom;
               step_pos(c);
               scan = 1'b0;
            end
         end
         default: scan_mode = ModeIdle;
      endcase

      if (scan) begin
         if (c == ChEos) begin
            keep(make_tok(TokEof, CodeNone, ChEos, at_off, '0, at_line, at_col));
            at_line = 16'd1;
            at_col  = 16'd1;
            at_off  = '0;
         end else if (space_ch(c)) begin
            step_pos(c);
         end else if (digit_ch(c)) begin
            open_tok(c);
            tok_len   = 16'd1;
            scan_mode = ModeNum;
            step_pos(c);
         end else if (c == ChQuote) begin
            open_tok(c);
            step_pos(c);
            tok_off   = at_off;
            scan_mode = ModeStr;
         end else if (c == ChSlash) begin
            open_tok(c);
            scan_mode = ModeSlash;
            step_pos(c);
         end else if (alpha_ch(c)) begin
            open_tok(c);
            word_hits = '1;
            narrow_words(c);
            tok_len   = 16'd1;
            scan_mode = ModeIdent;
            step_pos(c);
         end else begin
            keep(make_tok(punct_ch(c) ? TokPunct : TokOper, CodeNone, c, at_off,
                          16'd1, at_line, at_col));
            step_pos(c);
         end
      end

      if (fresh_n > 0) fresh[fresh_n-1].last = 1'b1;
      for (int i = 0; i < fresh_n; i++) tokens_due.push_back(fresh[i]);
   endfunction

   function automatic void field_check(string name, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      tok_type want;
      if (reset) begin
         tokens_due.delete();
         fail_count = 0;
         scan_mode  = ModeIdle;
         at_line    = 16'd1;
         at_col     = 16'd1;
         at_off     = '0;
         tok_off    = '0;
         tok_line   = 16'd1;
         tok_col    = 16'd1;
         tok_len    = '0;
         tok_ch     = '0;
         word_hits  = '1;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (tokens_due.size() == 0) begin
               $display("%0t: unexpected token, expected none, actual type %0d at %0d:%0d",
                        $time, rsp_mon.token_type, rsp_mon.line_number,
                        rsp_mon.column_number);
               fail_count++;
            end else begin
               want = tokens_due.pop_front();
               field_check("token_type", 16'(want.token_type), 16'(rsp_mon.token_type));
               field_check("word_code", 16'(want.word_code), 16'(rsp_mon.word_code));
               field_check("first_char", 16'(want.first_char), 16'(rsp_mon.first_char));
               field_check("start_offset", want.start_offset, rsp_mon.start_offset);
               field_check("token_length", want.token_length, rsp_mon.token_length);
               field_check("line_number", want.line_number, rsp_mon.line_number);
               field_check("column_number", want.column_number, rsp_mon.column_number);
               field_check("last", 16'(want.last), 16'(rsp_mon.last));
            end
         end
         if (req_mon.valid && req_mon.ready) lex_byte(req_mon.ch);
      end
      pending <= tokens_due.size();
   end

endmodule

// ===== dv/source_text_tokenizer_core_tb.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_core_tb
// Drives source bytes into the tokenizer: directed snippets for every token
// class, comment form and end-of-source case, then random token-shaped text
// with random idle and stall bursts and one long receiver hold-off.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core_tb;
   import stt_pkg::*;

   localparam int CycleLimit  = 2_000_000;
   localparam int RandomItems = 1750;
   localparam int QuietItems  = 350;
   localparam int HoldAfter   = 500;
   localparam int LongHold    = 300;
   localparam int DrainCycles = 16;

   logic  clock;
   logic  reset;
   int    fail_count;
   int    pending;
   int    items_sent;
   bit    idle_on;
   bit    stall_on;
   bit    hold_off;
   string glossary [8] = '{"var", "print", "function", "return",
                           "true", "false", "undefined", "null"};

   stt_req_if req_chan ();
   stt_rsp_if rsp_chan ();

   source_text_tokenizer_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   source_text_tokenizer_checker tok_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic send_byte(input logic [7:0] c);
      int gap;
      if (idle_on && ($urandom_range(0, 7) == 0)) begin
         gap = $urandom_range(1, 17);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.ch    <= c;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] pick_from(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   task automatic random_chunk();
      string      word;
      int         pick;
      int         n;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      n    = $urandom_range(0, 6);
      if (pick < 15) begin
         word = glossary[$urandom_range(0, 7)];
         case ($urandom_range(0, 3))
            1: word = word.substr(0, word.len() - 2);
            2: word = {word, "x"};
            default: ;
         endcase
         send_text(word);
         send_byte(pick_from(" ;(\n+"));
      end else if (pick < 30) begin
         send_byte(pick_from("abfinlrstuvxyzAZ_$"));
         repeat (n) send_byte(pick_from("aeflnrtuvAZ_$09"));
      end else if (pick < 40) begin
         send_byte(pick_from("0123456789"));
         repeat (n) send_byte(pick_from("0123456789."));
      end else if (pick < 50) begin
         send_byte(ChQuote);
         repeat (n) begin
            c = 8'($urandom_range(1, 255));
            send_byte((c == ChQuote) ? 8'h71 : c);
         end
         send_byte(ChQuote);
      end else if (pick < 55) begin
         send_text("//");
         repeat (n) begin
            c = 8'($urandom_range(1, 255));
            send_byte((c == ChLf) ? ChSpace : c);
         end
         send_byte(ChLf);
      end else if (pick < 62) begin
         send_text("/*");
         repeat (n) send_byte(pick_from("**/ a\n"));
         send_text("*/");
      end else if (pick < 67) begin
         send_byte(ChSlash);
         send_byte(pick_from(" a1(\"*/"));
      end else if (pick < 80) begin
         send_byte(pick_from("=;(){}.:,+-*<>!&|%#@"));
      end else if (pick < 90) begin
         send_byte(pick_from(" \t\r\n"));
      end else if (pick < 97) begin
         send_byte(8'($urandom_range(1, 255)));
      end else begin
         send_byte(ChEos);
      end
   endtask

   // token sink: random stall bursts, plus one long hold-off on request
   initial begin : sink_side
      int burst;
      bit held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off && !held) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (stall_on && ($urandom_range(0, 5) == 0)) begin
            burst = $urandom_range(1, 17);
            rsp_chan.ready <= 1'b0;
            repeat (burst) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("source_text_tokenizer_core_tb NOT OK");
      $finish;
   end

   initial begin : source_side
      int goal;
      int hold_at;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.ch    <= ChEos;
      idle_on   = 1'b1;
      stall_on  = 1'b1;
      hold_off  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_text("var print function return true false undefined null");
      send_text(" x_9 $q Var truex nul functio undefinedz\t\r\n");
      send_text("12.5.7 0 \"str ing\" \"\" a\"b\"=;(){}.:,+-<~");
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_byte(8'h01);
      send_text("\n// line note\na/b /* x ** y */c/**/d/ /");
      send_byte(ChEos);
      send_byte(ChEos);
      send_text("\"open");
      send_byte(ChEos);
      send_text("/* open *");
      send_byte(ChEos);
      send_text("// tail");
      send_byte(ChEos);
      send_text("/");
      send_byte(ChEos);
      send_text("42");
      send_byte(ChEos);
      send_text("word");
      send_byte(ChEos);

      goal     = items_sent + RandomItems;
      hold_at  = items_sent + HoldAfter;
      while (items_sent < goal) begin
         if (items_sent >= goal - QuietItems) begin
            idle_on  = 1'b0;
            stall_on = 1'b0;
         end
         if (items_sent >= hold_at) begin
            hold_off = 1'b1;
         end
         random_chunk();
      end
      send_byte(ChEos);
      req_chan.valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("source_text_tokenizer_core_tb OK");
      end else begin
         $display("source_text_tokenizer_core_tb NOT OK");
      end
      $finish;
   end

endmodule
